/* rtl/core/hsv2rgb_pkg.sv */
package hsv2rgb_pkg;

    localparam int unsigned CHAN_W    = 8;
    localparam int unsigned FRAC_BITS = 24;

    // hue sectors, 60 degrees each
    localparam logic [2:0] SEC_RED_YEL  = 3'd0;
    localparam logic [2:0] SEC_YEL_GRN  = 3'd1;
    localparam logic [2:0] SEC_GRN_CYN  = 3'd2;
    localparam logic [2:0] SEC_CYN_BLU  = 3'd3;
    localparam logic [2:0] SEC_BLU_MAG  = 3'd4;
    localparam logic [2:0] SEC_MAG_RED  = 3'd5;

    typedef struct packed {
        logic [CHAN_W-1:0] hue;
        logic [CHAN_W-1:0] saturation;
        logic [CHAN_W-1:0] brightness;
    } t_hsv_req;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_rgb_res;

endpackage

/* rtl/core/hsv_to_rgb_convert_core.sv */
// channel   dir  ports                    notes
// request   in   start, busy, i_request   taken when start && !busy
// result    out  o_done, o_result         o_done marks one cycle, no backpressure
//
// Four register stages: sector/fraction and s*v, v*(256-s) products; chroma
// term x; per-channel sums; final *255 scale and truncation.
// One request per clock; each result comes out of the fourth register stage on o_done.
// busy is always low: the pipeline never stalls since results cannot be held.
// Synchronous active-low reset clears the stage valid bits only.
module hsv_to_rgb_convert_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  hsv2rgb_pkg::t_hsv_req i_request,
    output logic                  o_done,
    output hsv2rgb_pkg::t_rgb_res o_result
);
    import hsv2rgb_pkg::*;

    localparam int unsigned SUM_W = FRAC_BITS;

    // valid bits
    logic r_vld1, r_vld2, r_vld3, r_vld4;

    // stage 1
    logic [2:0]  r_sec1, n_sec1;
    logic [8:0]  r_kk1,  n_kk1;
    logic [15:0] r_sv1,  n_sv1;
    logic [15:0] r_vm1,  n_vm1;
    logic [10:0] pos;
    logic [8:0]  s_inv;
    logic [16:0] vm_full;

    // stage 2
    logic [2:0]       r_sec2;
    logic [SUM_W-1:0] r_x2, n_x2;
    logic [SUM_W-1:0] r_c2, r_m2;
    logic [24:0]      x_full;

    // stage 3
    logic [SUM_W-1:0] r_rs3, n_rs3, r_gs3, n_gs3, r_bs3, n_bs3;

    // stage 4
    t_rgb_res r_res4, n_res4;
    logic [31:0] red_scl, g_scl, b_scl;

    assign busy = 1'b0;

    always_comb begin
        pos     = 11'({3'b0, i_request.hue}) * 11'd6;
        n_sec1  = pos[10:8];
        n_kk1   = pos[8] ? (9'd256 - {1'b0, pos[7:0]}) : {1'b0, pos[7:0]};
        n_sv1   = {8'b0, i_request.saturation} * {8'b0, i_request.brightness};
        s_inv   = 9'd256 - {1'b0, i_request.saturation};
        vm_full = {9'b0, i_request.brightness} * {8'b0, s_inv};
        n_vm1   = vm_full[15:0];
    end

    always_comb begin
        x_full = {9'b0, r_sv1} * {16'b0, r_kk1};
        n_x2   = x_full[SUM_W-1:0];
    end

    always_comb begin
        n_rs3 = r_m2;
        n_gs3 = r_m2;
        n_bs3 = r_m2;
        case (r_sec2)
            SEC_RED_YEL: begin
                n_rs3 = r_m2 + r_c2;
                n_gs3 = r_m2 + r_x2;
            end
            SEC_YEL_GRN: begin
                n_rs3 = r_m2 + r_x2;
                n_gs3 = r_m2 + r_c2;
            end
            SEC_GRN_CYN: begin
                n_gs3 = r_m2 + r_c2;
                n_bs3 = r_m2 + r_x2;
            end
            SEC_CYN_BLU: begin
                n_gs3 = r_m2 + r_x2;
                n_bs3 = r_m2 + r_c2;
            end
            SEC_BLU_MAG: begin
                n_rs3 = r_m2 + r_x2;
                n_bs3 = r_m2 + r_c2;
            end
            default: begin
                // magenta-red sector; codes above it never occur
                n_rs3 = r_m2 + r_c2;
                n_bs3 = r_m2 + r_x2;
            end
        endcase
    end

    // 255*sum = 256*sum - sum
    always_comb begin
        red_scl = {r_rs3, 8'b0} - {8'b0, r_rs3};
        g_scl   = {r_gs3, 8'b0} - {8'b0, r_gs3};
        b_scl   = {r_bs3, 8'b0} - {8'b0, r_bs3};
        n_res4.red   = red_scl[31:FRAC_BITS];
        n_res4.green = g_scl[31:FRAC_BITS];
        n_res4.blue  = b_scl[31:FRAC_BITS];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
        end else begin
            r_vld1 <= start && !busy;
            r_vld2 <= r_vld1;
            r_vld3 <= r_vld2;
            r_vld4 <= r_vld3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sec1 <= n_sec1;
        r_kk1  <= n_kk1;
        r_sv1  <= n_sv1;
        r_vm1  <= n_vm1;
        r_sec2 <= r_sec1;
        r_x2   <= n_x2;
        r_c2   <= {r_sv1, 8'b0};
        r_m2   <= {r_vm1, 8'b0};
        r_rs3  <= n_rs3;
        r_gs3  <= n_gs3;
        r_bs3  <= n_bs3;
        r_res4 <= n_res4;
    end

    assign o_done   = r_vld4;
    assign o_result = r_res4;

`ifndef SYNTH
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##4 o_done)
        else $error("request did not produce a result after 4 cycles");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start, 4))
        else $error("result without a matching request");

    a_x_le_c: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld2 |-> (r_x2 <= r_c2))
        else $error("secondary chroma exceeds chroma");

    a_out_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.red != 8'hFF && o_result.green != 8'hFF
                    && o_result.blue != 8'hFF))
        else $error("channel above 254");
`endif

endmodule

/* sim/hsv_to_rgb_convert_core_test.sv */
`timescale 1ns / 100ps

module hsv_to_rgb_convert_core_test;

    import hsv2rgb_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 4;
    localparam int RANDOM_PIXELS = 750;
    localparam int DRAIN_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 100000;
    localparam int REPORT_MAX   = 10;

    class rgb_scoreboard;
        t_rgb_res expected_rgb[$];
        t_hsv_req pending_hsv[$];
        int       errors;
        int       mismatches;
        int       pixels_sent;
        int       pixels_checked;

        function new();
            errors         = 0;
            mismatches     = 0;
            pixels_sent    = 0;
            pixels_checked = 0;
        endfunction

        // exact 24-bit fraction math, truncated once at the end
        static function t_rgb_res convert_pixel(t_hsv_req px);
            logic [63:0] h, s, v, pos, k, c, m, x, r, g, b;
            logic [2:0]  sector;
            t_rgb_res    res;
            h      = 64'(px.hue);
            s      = 64'(px.saturation);
            v      = 64'(px.brightness);
            pos    = h * 6;
            sector = pos[10:8];
            k      = pos & 64'hFF;
            c      = s * v * 256;
            m      = v * 256 * (256 - s);
            x      = sector[0] ? s * v * (256 - k) : s * v * k;
            case (sector)
                SEC_RED_YEL: begin r = c; g = x; b = 0; end
                SEC_YEL_GRN: begin r = x; g = c; b = 0; end
                SEC_GRN_CYN: begin r = 0; g = c; b = x; end
                SEC_CYN_BLU: begin r = 0; g = x; b = c; end
                SEC_BLU_MAG: begin r = x; g = 0; b = c; end
                default: begin r = c; g = 0; b = x; end
            endcase
            res.red   = 8'(((r + m) * 255) >> FRAC_BITS);
            res.green = 8'(((g + m) * 255) >> FRAC_BITS);
            res.blue  = 8'(((b + m) * 255) >> FRAC_BITS);
            return res;
        endfunction

        function void note_request(t_hsv_req px);
            expected_rgb.push_back(convert_pixel(px));
            pending_hsv.push_back(px);
            pixels_sent++;
        endfunction

        function void check_result(t_rgb_res got);
            t_rgb_res want;
            t_hsv_req src;
            if (expected_rgb.size() == 0) begin
                errors++;
                $display("ERROR: unexpected result r=%0d g=%0d b=%0d",
                         got.red, got.green, got.blue);
                return;
            end
            want = expected_rgb.pop_front();
            src  = pending_hsv.pop_front();
            pixels_checked++;
            if (got.red !== want.red || got.green !== want.green ||
                got.blue !== want.blue) begin
                errors++;
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("ERROR: h=%0d s=%0d v=%0d exp (%0d,%0d,%0d) got (%0d,%0d,%0d)",
                             src.hue, src.saturation, src.brightness,
                             want.red, want.green, want.blue,
                             got.red, got.green, got.blue);
            end
        endfunction

        function int pending();
            return expected_rgb.size();
        endfunction
    endclass

    logic     i_clk;
    logic     i_rst_n;
    logic     start;
    logic     busy;
    t_hsv_req i_request;
    logic     o_done;
    t_rgb_res o_result;

    rgb_scoreboard sb;
    int            cycle_count;

    hsv_to_rgb_convert_core dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_request (i_request),
        .o_done    (o_done),
        .o_result  (o_result)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("ERROR: timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // request and result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy)
            sb.note_request(i_request);
        if (o_done === 1'b1)
            sb.check_result(o_result);
    end

    // holds start high until the request is taken, returns at the next falling edge
    task automatic send_pixel(input logic [7:0] h, input logic [7:0] s, input logic [7:0] v);
        start                = 1'b1;
        i_request.hue        = h;
        i_request.saturation = s;
        i_request.brightness = v;
        do @(posedge i_clk); while (busy !== 1'b0);
        @(negedge i_clk);
    endtask

    task automatic idle_cycles(input int n);
        start = 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    task automatic wait_results_drained();
        start = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    function automatic logic [7:0] rand_chan();
        int pick;
        pick = $urandom_range(0, 15);
        if (pick == 0) return 8'd0;
        if (pick == 1) return 8'd255;
        return 8'($urandom_range(0, 255));
    endfunction

    initial begin
        logic [7:0] edge_hues[12];
        int         sent;
        int         burst;
        sb          = new();
        cycle_count = 0;
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_request   = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // extremes, gray and black pixels
        send_pixel(8'd0,   8'd0,   8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd0,   8'd255, 8'd255);
        send_pixel(8'd77,  8'd0,   8'd200);
        send_pixel(8'd200, 8'd0,   8'd255);
        send_pixel(8'd150, 8'd255, 8'd0);
        send_pixel(8'd33,  8'd128, 8'd0);
        // first and last hue of every sector
        edge_hues = '{8'd0, 8'd42, 8'd43, 8'd85, 8'd86, 8'd127,
                      8'd128, 8'd170, 8'd171, 8'd213, 8'd214, 8'd255};
        foreach (edge_hues[i])
            send_pixel(edge_hues[i], 8'd255, 8'd255);
        send_pixel(8'd43,  8'd1,   8'd1);
        send_pixel(8'd214, 8'd128, 8'd255);
        idle_cycles(3);

        sent = 0;
        while (sent < RANDOM_PIXELS) begin
            burst = $urandom_range(1, 24);
            for (int i = 0; i < burst && sent < RANDOM_PIXELS; i++) begin
                send_pixel(8'($urandom_range(0, 255)), rand_chan(), rand_chan());
                sent++;
            end
            if (sent >= RANDOM_PIXELS / 2 && sent - burst < RANDOM_PIXELS / 2)
                wait_results_drained();
            else if ($urandom_range(0, 3) != 0)
                idle_cycles($urandom_range(1, 7));
        end

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0) begin
            sb.errors++;
            $display("ERROR: %0d results never arrived", sb.pending());
        end
        if (sb.mismatches > REPORT_MAX)
            $display("%0d mismatches in total", sb.mismatches);
        $display("Converted %0d pixels, %0d results checked, over all six hue sectors",
                 sb.pixels_sent, sb.pixels_checked);
        $display("with gray, black and full-range inputs in bursts and gaps");
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/hsv2rgb_pkg.sv
rtl/core/hsv_to_rgb_convert_core.sv
sim/hsv_to_rgb_convert_core_test.sv
